// ----- design/spd_pkg.sv -----
`timescale 1ns / 1ps

package spd_pkg;

  // defaults for the top level parameters
  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths
  localparam int NODE_FIELD_BITS = 5;
  localparam int EDGE_FIELD_BITS = 16;
  localparam int DIST_BITS       = 22;
  localparam int PARENT_BITS     = 6;
  localparam int CNT_BITS        = 7;   // holds node counts up to 64
  localparam int NC_BITS         = 6;   // node_count register

  localparam logic [DIST_BITS-1:0]   DIST_INF  = {DIST_BITS{1'b1}};
  localparam logic [PARENT_BITS-1:0] NO_PARENT = {PARENT_BITS{1'b1}};

  // input commands (tuser)
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  localparam logic [NC_BITS-1:0]         NODE_COUNT_RST  = NC_BITS'(32);
  localparam logic [NODE_FIELD_BITS-1:0] SOURCE_NODE_RST = '0;

  // search setup handed from the register file to the sequencer
  typedef struct packed {
    logic [CNT_BITS-1:0]        nodes;  // node count in use, 1..MAX_NODES
    logic [NODE_FIELD_BITS-1:0] src;    // source node as written
  } spd_cfg_t;

endpackage

// ----- design/shortest_path_dense_graph_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir   Fields
// -------   ---   ---------------------------------------------------------
// in_*      in    tuser: cmd; tdata: from_node, to_node, edge_weight
// out_*     out   tdata: node_index, path_length, parent_node; tlast: last
// cfg_*     in    APB-style: node_count at 0x0, source_node at 0x4
//
// A load transaction writes one matrix entry.
// A start transaction runs R <= N-1 rounds, N nodes in use, and stops early
// when a round finds no reachable node: each round is one pass over the
// distance table to find the closest unvisited node and one pass over its
// matrix row to relax edges, one entry a cycle through the single distance
// memory read port and shared add/compare unit. Results then leave at up to
// one per cycle.
// in_tready is high only while idle; out_tready stalls only the result drain.
// Reset (rst_n, synchronous) clears control state; the matrix is not cleared.
module shortest_path_dense_graph_core #(
  parameter int MAX_NODES   = spd_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [4:0] from_node, [9:5] to_node, [25:10] edge_weight
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] node_index, [26:5] path_length, [32:27] parent_node
  output logic        out_tlast,  // last_result
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import spd_pkg::*;

  logic [NC_BITS-1:0]         node_count_r;
  logic [NODE_FIELD_BITS-1:0] source_node_r;
  logic                       cfg_wr;
  logic                       reg_sel;
  spd_cfg_t                   cfg;

  logic [NODE_FIELD_BITS-1:0]   res_node;
  logic [DIST_BITS-1:0]         res_len;
  logic signed [PARENT_BITS-1:0] res_par;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_RST;
      source_node_r <= SOURCE_NODE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_NODE_COUNT:  node_count_r  <= cfg_pwdata[NC_BITS-1:0];
        REG_SOURCE_NODE: source_node_r <= cfg_pwdata[NODE_FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_COUNT:  cfg_prdata = 32'(node_count_r);
      REG_SOURCE_NODE: cfg_prdata = 32'(source_node_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // node count in use: zero reads as one, clamp at the array size
  always_comb begin
    if (node_count_r == '0) begin
      cfg.nodes = CNT_BITS'(1);
    end else if (CNT_BITS'(node_count_r) > CNT_BITS'(MAX_NODES)) begin
      cfg.nodes = CNT_BITS'(MAX_NODES);
    end else begin
      cfg.nodes = CNT_BITS'(node_count_r);
    end
    cfg.src = source_node_r;
  end

  spd_ctrl #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid_i   (in_tvalid),
    .in_ready_o   (in_tready),
    .in_cmd_i     (in_tuser[0]),
    .in_from_i    (in_tdata[4:0]),
    .in_to_i      (in_tdata[9:5]),
    .in_weight_i  (in_tdata[25:10]),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_node_o   (res_node),
    .out_len_o    (res_len),
    .out_parent_o (res_par),
    .out_last_o   (out_tlast)
  );

  assign out_tdata = {7'b0, res_par, res_len, res_node};

endmodule

// ----- design/spd_alu.sv -----
`timescale 1ns / 1ps

// Shared saturating add and less-than compare.
module spd_alu #(
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic [spd_pkg::DIST_BITS-1:0] base_i,
  input  logic [WEIGHT_BITS-1:0]        addend_i,
  input  logic [spd_pkg::DIST_BITS-1:0] bound_i,
  output logic [spd_pkg::DIST_BITS-1:0] sum_o,
  output logic                          lt_o
);
  import spd_pkg::*;

  localparam int SUM_W = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  logic [SUM_W-1:0] sum_full;

  assign sum_full = SUM_W'(base_i) + SUM_W'(addend_i);
  assign sum_o    = (sum_full > SUM_W'(DIST_INF)) ? DIST_INF : sum_full[DIST_BITS-1:0];
  assign lt_o     = sum_o < bound_i;

endmodule

// ----- design/spd_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer, weight and distance memories, result register.
module spd_ctrl #(
  parameter int MAX_NODES   = spd_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spd_pkg::spd_cfg_t                    cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_cmd_i,
  input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  in_from_i,
  input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  in_to_i,
  input  logic [spd_pkg::EDGE_FIELD_BITS-1:0]  in_weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [spd_pkg::NODE_FIELD_BITS-1:0]  out_node_o,
  output logic [spd_pkg::DIST_BITS-1:0]        out_len_o,
  output logic signed [spd_pkg::PARENT_BITS-1:0] out_parent_o,
  output logic                                 out_last_o
);
  import spd_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = DIST_BITS + PARENT_BITS;
  localparam logic [WEIGHT_BITS-1:0] W_NONE = {WEIGHT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN, S_PICK, S_RELAX, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    round_r, round_nxt;
  logic [NODE_W-1:0]   cand_idx_r, cand_idx_nxt;
  logic                cand_vld_r, cand_vld_nxt;
  logic [DIST_BITS-1:0] least_r, least_nxt;
  logic [NODE_W-1:0]   pick_r, pick_nxt;
  logic                found_r, found_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] touched_r, touched_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_FIELD_BITS-1:0] out_node_r, out_node_nxt;
  logic [DIST_BITS-1:0] out_len_r, out_len_nxt;
  logic [PARENT_BITS-1:0] out_par_r, out_par_nxt;
  logic                out_last_r, out_last_nxt;

  // memories
  logic [WEIGHT_BITS-1:0] w_mem [DEPTH];
  logic [WORD_W-1:0]      d_mem [MAX_NODES];
  logic [WEIGHT_BITS-1:0] w_q;
  logic [WORD_W-1:0]      rd_word;
  logic                   touched_q;

  logic                   w_we;
  logic [AW-1:0]          w_waddr, w_raddr;
  logic                   d_we;
  logic [NODE_W-1:0]      d_waddr, rd_addr;
  logic [WORD_W-1:0]      d_wdata;

  logic [CNT_W-1:0]       n_w;
  logic                   issue;
  logic                   src_ok;
  logic                   load_ok;
  logic [DIST_BITS-1:0]   dist_eff;
  logic [PARENT_BITS-1:0] par_eff;
  logic                   out_free;
  logic                   emit_last;

  logic [DIST_BITS-1:0]   alu_base, alu_bound, alu_sum;
  logic [WEIGHT_BITS-1:0] alu_add;
  logic                   alu_lt;

  assign n_w      = CNT_W'(cfg_i.nodes);
  assign issue    = idx_r < n_w;
  assign src_ok   = CNT_BITS'(cfg_i.src) < cfg_i.nodes;
  assign load_ok  = (CNT_BITS'(in_from_i) < CNT_BITS'(MAX_NODES)) &&
                    (CNT_BITS'(in_to_i) < CNT_BITS'(MAX_NODES));
  assign dist_eff = touched_q ? rd_word[WORD_W-1:PARENT_BITS] : DIST_INF;
  assign par_eff  = touched_q ? rd_word[PARENT_BITS-1:0] : NO_PARENT;
  assign out_free = !out_valid_r || out_ready_i;
  assign emit_last = (idx_r + CNT_W'(1)) == n_w;

  assign in_ready_o   = (state_r == S_IDLE);
  assign out_valid_o  = out_valid_r;
  assign out_node_o   = out_node_r;
  assign out_len_o    = out_len_r;
  assign out_parent_o = out_par_r;
  assign out_last_o   = out_last_r;

  // scan: dist < least; relax: sat(least + w) < dist
  always_comb begin
    if (state_r == S_RELAX) begin
      alu_base  = least_r;
      alu_add   = w_q;
      alu_bound = dist_eff;
    end else begin
      alu_base  = dist_eff;
      alu_add   = '0;
      alu_bound = least_r;
    end
  end

  spd_alu #(.WEIGHT_BITS(WEIGHT_BITS)) u_alu (
    .base_i   (alu_base),
    .addend_i (alu_add),
    .bound_i  (alu_bound),
    .sum_o    (alu_sum),
    .lt_o     (alu_lt)
  );

  assign w_we    = (state_r == S_IDLE) && in_valid_i && (in_cmd_i == CMD_LOAD) && load_ok;
  assign w_waddr = AW'(in_from_i) * AW'(MAX_NODES) + AW'(in_to_i);
  assign w_raddr = AW'(pick_r) * AW'(MAX_NODES) + AW'(idx_r[NODE_W-1:0]);

  always_comb begin
    rd_addr = idx_r[NODE_W-1:0];
    if (state_r == S_EMIT_LD && out_free && !emit_last) begin
      rd_addr = NODE_W'(idx_r + CNT_W'(1));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    round_nxt     = round_r;
    cand_idx_nxt  = idx_r[NODE_W-1:0];
    cand_vld_nxt  = 1'b0;
    least_nxt     = least_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    visited_nxt   = visited_r;
    touched_nxt   = touched_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_node_nxt  = out_node_r;
    out_len_nxt   = out_len_r;
    out_par_nxt   = out_par_r;
    out_last_nxt  = out_last_r;
    d_we          = 1'b0;
    d_waddr       = cand_idx_r;
    d_wdata       = {alu_sum, PARENT_BITS'(pick_r)};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid_i && in_cmd_i == CMD_START) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        visited_nxt = '0;
        touched_nxt = '0;
        round_nxt   = '0;
        idx_nxt     = '0;
        least_nxt   = DIST_INF;
        found_nxt   = 1'b0;
        if (src_ok) begin
          touched_nxt[NODE_W'(cfg_i.src)] = 1'b1;
          d_we      = 1'b1;
          d_waddr   = NODE_W'(cfg_i.src);
          d_wdata   = {{DIST_BITS{1'b0}}, NO_PARENT};
          state_nxt = (n_w > CNT_W'(1)) ? S_SCAN : S_EMIT_RD;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_SCAN: begin
        if (cand_vld_r && !visited_r[cand_idx_r] && alu_lt) begin
          least_nxt = alu_sum;
          pick_nxt  = cand_idx_r;
          found_nxt = 1'b1;
        end
        if (issue) begin
          cand_vld_nxt = 1'b1;
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        idx_nxt = '0;
        if (found_r) begin
          visited_nxt[pick_r] = 1'b1;
          round_nxt           = round_r + CNT_W'(1);
          state_nxt           = S_RELAX;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_RELAX: begin
        if (cand_vld_r && w_q != W_NONE && alu_lt) begin
          d_we                    = 1'b1;
          touched_nxt[cand_idx_r] = 1'b1;
        end
        if (issue) begin
          cand_vld_nxt = 1'b1;
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          idx_nxt = '0;
          if ((round_r + CNT_W'(1)) < n_w) begin
            least_nxt = DIST_INF;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_FIELD_BITS'(idx_r);
          out_len_nxt   = dist_eff;
          out_par_nxt   = par_eff;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      round_r     <= '0;
      cand_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      visited_r   <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      round_r     <= round_nxt;
      cand_vld_r  <= cand_vld_nxt;
      found_r     <= found_nxt;
      visited_r   <= visited_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_idx_r <= cand_idx_nxt;
    least_r    <= least_nxt;
    pick_r     <= pick_nxt;
    out_node_r <= out_node_nxt;
    out_len_r  <= out_len_nxt;
    out_par_r  <= out_par_nxt;
    out_last_r <= out_last_nxt;
  end

  // weight matrix, one write and one registered read port
  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= WEIGHT_BITS'(in_weight_i);
    end
    w_q <= w_mem[w_raddr];
  end

  // distance / parent table; untouched entries read as unreached
  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[d_waddr] <= d_wdata;
    end
    rd_word   <= d_mem[rd_addr];
    touched_q <= touched_r[rd_addr];
  end

endmodule
